// ===== rtl/sortab_pkg.sv =====
package sortab_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

endpackage

// ===== rtl/sortab_req_if.sv =====
interface sortab_req_if import sortab_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;

    modport source (output valid, output op, output value, output index, input ready);
    modport sink   (input valid, input op, input value, input index, output ready);
endinterface

// ===== rtl/sortab_rsp_if.sv =====
interface sortab_rsp_if import sortab_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink   (input valid, input status, input position, input count, output ready);
endinterface

// ===== rtl/sortab_ram.sv =====
module sortab_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sorted_table_insert_delete_search.sv =====
// Channel   Dir  Payload                       Transfer
// i_req     in   op, value (s32), index        i_req.valid && i_req.ready
// o_rsp     out  status, position, count       o_rsp.valid && o_rsp.ready
//
// Walk: search goes up from the bottom entry, insert down from the top, delete up
//   from above the index; full, out-of-range, empty and unused-op requests skip it.
//   One table entry is visited per cycle through the single read port of the RAM.
// Reset: i_rst_n (synchronous, active low) empties the table; entry storage is not
//   cleared, entries above the count are never read.
// Stalls: i_req.ready is high only between requests; a result may wait in the
//   output register while the next request is taken and worked on.
module sorted_table_insert_delete_search import sortab_pkg::*; #(
    parameter int  CAPACITY = CAPACITY_DEF,
    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW   = $clog2(CAPACITY + 1),
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W,
    localparam int PW   = (CW > COUNT_W) ? CW : COUNT_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sortab_req_if.sink   i_req,
    sortab_rsp_if.source o_rsp
);

    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // One-hot sequencer: take a request, walk the table, put the new value, report.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_PUT  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic signed [31:0]  r_val, n_val;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_count, n_count;
    t_status             r_res_status, n_res_status;
    logic [CW-1:0]       r_res_pos, n_res_pos;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [POS_W-1:0]    r_out_pos;
    logic [COUNT_W-1:0]  r_out_count;

    // Table storage port signals
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [31:0]         wr_data;
    logic [AW-1:0]       rd_addr;
    logic signed [31:0]  rd_data;
    logic [CMPW-1:0]     rd_ptr;

    logic [CW-1:0]       ptr_up, ptr_dn;
    logic                ptr_last;
    logic [CMPW-1:0]     idx_ext, cnt_ext;
    logic                out_load;
    logic [PW-1:0]       pos_ext, cnt_out_ext;

    sortab_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign ptr_up   = r_ptr + 1'b1;
    assign ptr_dn   = r_ptr - 1'b1;
    assign ptr_last = (r_ptr == r_count - 1'b1);
    assign idx_ext  = CMPW'(i_req.index);
    assign cnt_ext  = CMPW'(r_count);
    assign rd_addr  = rd_ptr[AW-1:0];

    assign i_req.ready = (r_state == S_IDLE);
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_val        = r_val;
        n_ptr        = r_ptr;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = r_val;
        rd_ptr       = CMPW'(ptr_up);

        case (r_state)
            S_IDLE: begin
                // Prime the first read so data is ready on the first scan cycle
                case (i_req.op)
                    OP_INSERT: rd_ptr = CMPW'(r_count - 1'b1);
                    OP_DELETE: rd_ptr = CMPW'(idx_ext + 1'b1);
                    default:   rd_ptr = '0;
                endcase

                if (i_req.valid) begin
                    n_op         = t_op'(i_req.op);
                    n_val        = i_req.value;
                    n_res_status = ST_OK;
                    n_res_pos    = '0;
                    n_state      = S_DONE;
                    case (i_req.op)
                        OP_INSERT: begin
                            if (r_count == CAP_CNT) begin
                                n_res_status = ST_FULL;
                            end else if (r_count == '0) begin
                                wr_en   = 1'b1;
                                wr_data = i_req.value;
                                n_count = r_count + 1'b1;
                            end else begin
                                // Walk down from the top entry
                                n_ptr   = r_count - 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        OP_DELETE: begin
                            if (idx_ext >= cnt_ext) begin
                                n_res_status = ST_RANGE;
                            end else if (idx_ext == cnt_ext - 1'b1) begin
                                // Top entry: nothing to close up
                                n_count = r_count - 1'b1;
                            end else begin
                                n_ptr   = CW'(idx_ext + 1'b1);
                                n_state = S_SCAN;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_res_status = ST_MISSING;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                case (r_op)
                    OP_INSERT: begin
                        rd_ptr  = CMPW'(ptr_dn);
                        wr_en   = 1'b1;
                        wr_addr = ptr_up[AW-1:0];
                        if (rd_data > r_val) begin
                            // Larger entry moves up one place
                            wr_data = rd_data;
                            if (r_ptr == '0) begin
                                n_res_pos = '0;
                                n_state   = S_PUT;
                            end else begin
                                n_ptr = ptr_dn;
                            end
                        end else begin
                            // New value lands just above the last entry not larger
                            wr_data   = r_val;
                            n_res_pos = ptr_up;
                            n_count   = r_count + 1'b1;
                            n_state   = S_DONE;
                        end
                    end
                    OP_DELETE: begin
                        wr_en   = 1'b1;
                        wr_addr = ptr_dn[AW-1:0];
                        wr_data = rd_data;
                        if (ptr_last) begin
                            n_count = r_count - 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_ptr = ptr_up;
                        end
                    end
                    OP_SEARCH: begin
                        if (rd_data == r_val) begin
                            n_res_status = ST_OK;
                            n_res_pos    = r_ptr;
                            n_state      = S_DONE;
                        end else if (rd_data > r_val || ptr_last) begin
                            n_res_status = ST_MISSING;
                            n_state      = S_DONE;
                        end else begin
                            n_ptr = ptr_up;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_PUT: begin
                // Every entry was larger: new value goes to the bottom
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_val;
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign pos_ext     = PW'(r_res_pos);
    assign cnt_out_ext = PW'(r_count);

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_val        <= n_val;
        r_ptr        <= n_ptr;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_pos    <= pos_ext[POS_W-1:0];
            r_out_count  <= cnt_out_ext[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.position = r_out_pos;
    assign o_rsp.count    = r_out_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count above capacity");

    a_scan_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr < r_count))
        else $error("scan pointer outside occupied range");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == ST_FULL) |-> (r_count == CAP_CNT))
        else $error("full reported while table has room");

    a_no_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !wr_en)
        else $error("table written while reporting");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sortab_pkg::*;

    localparam int TABLE_DEPTH    = CAPACITY_DEF;
    localparam int RANDOM_ITEMS   = 1620;
    localparam int PAUSE_AT_ITEM  = 900;   // sender waits for a drained pipe here
    localparam int HOLD_AT_RESULT = 300;   // receiver starts its long hold-off here
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * (TABLE_DEPTH + 4);
    localparam int DIRECTED_ROWS  = 27;

    // The op field has a fourth code that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } table_result_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
        bit                        known;   // result typed in below, not predicted
        table_result_t             result;
    } request_row_t;

    typedef enum int {
        RUN_FILL,
        RUN_DRAIN,
        RUN_MIXED
    } run_kind_t;

    logic i_clk;
    logic i_rst_n;

    sortab_req_if req_ch ();
    sortab_rsp_if rsp_ch ();

    sorted_table_insert_delete_search #(
        .CAPACITY (TABLE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the sorted table, updated at every accepted request.
    logic signed [VALUE_W-1:0] shadow_entries [TABLE_DEPTH];
    int                        shadow_count;

    table_result_t awaited_results [$];
    int            mismatch_count;
    bit            quiet_run;      // no random idling on either side while set

    request_row_t  directed_rows [DIRECTED_ROWS];

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Table predictor: apply one request to the shadow table and return the
    // result the block must give for it.
    // ------------------------------------------------------------------
    function automatic table_result_t predict_table_op(input logic [OP_W-1:0] op,
                                                       input logic signed [VALUE_W-1:0] val,
                                                       input logic [INDEX_W-1:0] idx);
        table_result_t r;
        int            i;
        int            k;
        bit            hit;
        r.status   = ST_OK;
        r.position = '0;
        case (op)
            OP_INSERT: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // Land after any equal entries: skip everything not larger.
                    i = 0;
                    while (i < shadow_count && shadow_entries[i] <= val) i++;
                    for (k = shadow_count; k > i; k--) shadow_entries[k] = shadow_entries[k-1];
                    shadow_entries[i] = val;
                    shadow_count++;
                    r.position = POS_W'(i);
                end
            end
            OP_DELETE: begin
                if (int'(idx) >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = int'(idx); k < shadow_count - 1; k++)
                        shadow_entries[k] = shadow_entries[k+1];
                    shadow_count--;
                end
            end
            OP_SEARCH: begin
                // First equal entry wins; stop as soon as entries pass the key.
                r.status = ST_MISSING;
                hit = 1'b0;
                i = 0;
                while (!hit && i < shadow_count && shadow_entries[i] <= val) begin
                    if (shadow_entries[i] == val) begin
                        hit        = 1'b1;
                        r.status   = ST_OK;
                        r.position = POS_W'(i);
                    end
                    i++;
                end
            end
            default: ;  // unused code: table untouched, status ok
        endcase
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet_run) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Values lean toward a narrow band (duplicates, search hits), copies of
    // held entries, and the ends of the signed range.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int s;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                s = $urandom_range(16);
                return s - 8;
            end
            4, 5: begin
                if (shadow_count > 0) return shadow_entries[$urandom_range(shadow_count - 1)];
                return $urandom;
            end
            6: begin
                case ($urandom_range(5))
                    0:       return VALUE_MIN;
                    1:       return VALUE_MAX;
                    2:       return VALUE_MIN + 1;
                    3:       return VALUE_MAX - 1;
                    4:       return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic request_row_t req_row(input logic [OP_W-1:0] op,
                                             input logic signed [VALUE_W-1:0] val,
                                             input logic [INDEX_W-1:0] idx);
        request_row_t row;
        row.op     = op;
        row.value  = val;
        row.index  = idx;
        row.known  = 1'b0;
        row.result = '0;
        return row;
    endfunction

    function automatic request_row_t req_row_known(input logic [OP_W-1:0] op,
                                                   input logic signed [VALUE_W-1:0] val,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input t_status st,
                                                   input int pos,
                                                   input int cnt);
        request_row_t row;
        row                 = req_row(op, val, idx);
        row.known           = 1'b1;
        row.result.status   = st;
        row.result.position = POS_W'(pos);
        row.result.count    = COUNT_W'(cnt);
        return row;
    endfunction

    // Offer one request, hold it until the block takes it, then queue the
    // result it must produce. A zero gap keeps valid high straight through.
    task automatic send_request(input request_row_t row);
        int            gap;
        table_result_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= row.op;
        req_ch.value <= row.value;
        req_ch.index <= row.index;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        predicted = predict_table_op(row.op, row.value, row.index);
        awaited_results.push_back(row.known ? row.result : predicted);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random runs, drain
    // ------------------------------------------------------------------
    initial begin : stimulus
        int           n;
        int           r;
        int           run_left;
        run_kind_t    run_kind;
        request_row_t row;

        req_ch.valid   <= 1'b0;
        req_ch.op      <= OP_INSERT;
        req_ch.value   <= '0;
        req_ch.index   <= '0;
        i_rst_n        <= 1'b0;
        mismatch_count = 0;
        shadow_count   = 0;
        quiet_run      = 1'b0;
        run_left       = 0;
        run_kind       = RUN_FILL;

        // Fill to capacity with the ends of the range and a duplicate, then
        // probe full, first/last hits, a miss, and both sides of the range
        // check on delete.
        directed_rows = '{
            req_row_known(OP_SEARCH, 0, 0, ST_MISSING, 0, 0),      // empty table
            req_row_known(OP_DELETE, 0, 0, ST_RANGE, 0, 0),        // empty table
            req_row_known(OP_UNUSED, -1, 15, ST_OK, 0, 0),
            req_row_known(OP_INSERT, 0, 0, ST_OK, 0, 1),
            req_row_known(OP_INSERT, VALUE_MIN, 0, ST_OK, 0, 2),
            req_row_known(OP_INSERT, VALUE_MAX, 0, ST_OK, 2, 3),
            req_row_known(OP_INSERT, 0, 0, ST_OK, 2, 4),           // after the equal one
            req_row(OP_INSERT, -1, 15),
            req_row(OP_INSERT, 32'sh5555_5555, 0),
            req_row(OP_INSERT, 32'shAAAA_AAAA, 0),
            req_row(OP_INSERT, 1, 0),
            req_row(OP_INSERT, -2, 0),
            req_row(OP_INSERT, 100, 0),
            req_row(OP_INSERT, -100, 0),
            req_row(OP_INSERT, 7, 0),
            req_row(OP_INSERT, 32'sh4000_0000, 0),
            req_row(OP_INSERT, 32'shC000_0000, 0),
            req_row(OP_INSERT, 42, 0),
            req_row(OP_INSERT, 9, 0),
            req_row_known(OP_INSERT, 5, 0, ST_FULL, 0, 16),
            req_row_known(OP_SEARCH, VALUE_MIN, 0, ST_OK, 0, 16),
            req_row_known(OP_SEARCH, VALUE_MAX, 0, ST_OK, 15, 16),
            req_row(OP_SEARCH, 0, 0),                              // first of two zeros
            req_row(OP_SEARCH, 3, 0),                              // miss, stops at 7
            req_row_known(OP_DELETE, 0, 15, ST_OK, 0, 15),
            req_row_known(OP_DELETE, 0, 15, ST_RANGE, 0, 15),      // index equals count
            req_row_known(OP_UNUSED, 0, 0, ST_OK, 0, 15)           // count unchanged
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIRECTED_ROWS; n++) send_request(directed_rows[n]);

        // Random runs: each run leans toward filling, draining or a mix, so the
        // table keeps swinging between empty and full.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (run_left == 0) begin
                run_left  = $urandom_range(60, 10);
                run_kind  = run_kind_t'($urandom_range(2));
                quiet_run = ($urandom_range(7) == 0);
            end
            run_left--;

            // Hold valid low until every queued result has come back.
            if (n == PAUSE_AT_ITEM) begin
                req_ch.valid <= 1'b0;
                do @(posedge i_clk); while (awaited_results.size() != 0);
            end

            r = $urandom_range(99);
            case (run_kind)
                RUN_FILL:  r = (r < 70) ? 0 : (r < 80) ? 1 : (r < 98) ? 2 : 3;
                RUN_DRAIN: r = (r < 15) ? 0 : (r < 80) ? 1 : (r < 98) ? 2 : 3;
                default:   r = (r < 35) ? 0 : (r < 65) ? 1 : (r < 98) ? 2 : 3;
            endcase

            row = req_row(OP_INSERT, pick_value(), INDEX_W'($urandom_range(15)));
            case (r)
                1: begin
                    row.op    = OP_DELETE;
                    row.value = $urandom;
                    if (shadow_count > 0 && $urandom_range(99) < 85)
                        row.index = INDEX_W'($urandom_range(shadow_count - 1));
                end
                2: begin
                    row.op = OP_SEARCH;
                    if (shadow_count > 0 && $urandom_range(99) < 60)
                        row.value = shadow_entries[$urandom_range(shadow_count - 1)];
                end
                3: row.op = OP_UNUSED;
                default: ;
            endcase
            send_request(row);
        end

        // Drop valid, let the queue drain, then give stray results a chance.
        req_ch.valid <= 1'b0;
        quiet_run = 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("sorted_table_insert_delete_search verification clean");
        end else begin
            $display("sorted_table_insert_delete_search verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure, one long hold-off, and the check of
    // every transfer against the oldest queued result.
    // ------------------------------------------------------------------
    initial begin : result_checker
        int            stall_left;
        int            results_seen;
        bit            held_off;
        table_result_t want;

        stall_left   = 0;
        results_seen = 0;
        held_off     = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d position %0d count %0d",
                             $time, rsp_ch.status, rsp_ch.position, rsp_ch.count);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", 8'(want.status), 8'(rsp_ch.status));
                    check_field("position", 8'(want.position), 8'(rsp_ch.position));
                    check_field("count", 8'(want.count), 8'(rsp_ch.count));
                end
            end

            // Hold ready low long enough for the block to back up into its
            // request side while the sender keeps offering.
            if (results_seen == HOLD_AT_RESULT && !held_off) begin
                held_off   = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && $urandom_range(3) == 0) begin
                stall_left = pick_gap();
            end

            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when neither channel has moved for too long.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("sorted_table_insert_delete_search verification failed");
        $finish;
    end

endmodule
